@@ rtl/core/uvnh_pkg.sv @@
// Package for the UUID v5 namespace hash core: payload types, SHA-1 constants.
// No dependencies.
`default_nettype none
package uvnh_pkg;

    typedef struct packed {
        logic [63:0] name_uuid_high;
        logic [63:0] name_uuid_low;
    } in_word_t;

    typedef struct packed {
        logic [63:0] derived_uuid_high;
        logic [63:0] derived_uuid_low;
    } out_word_t;

    localparam int unsigned CfgIdxW = 1;
    localparam int unsigned CfgDataW = 1;
    localparam logic [CfgIdxW-1:0] REG_SWAP_IN = 1'b0;
    localparam logic [CfgIdxW-1:0] REG_SWAP_OUT = 1'b1;

    localparam int unsigned Rounds = 80;
    localparam logic [127:0] NAMESPACE = 128'h2A061990D38D4440A139C497703765AC;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } sha_state_t;

    function automatic logic [63:0] swap_fields(input logic [63:0] x);
        return {x[39:32], x[47:40], x[55:48], x[63:56],
                x[23:16], x[31:24], x[7:0], x[15:8]};
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] i);
        logic [31:0] k;
        if (i < 7'd20) k = 32'h5A827999;
        else if (i < 7'd40) k = 32'h6ED9EBA1;
        else if (i < 7'd60) k = 32'h8F1BBCDC;
        else k = 32'hCA62C1D6;
        return k;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] i, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (i < 7'd20) f = (b & c) | (~b & d);
        else if (i < 7'd40) f = b ^ c ^ d;
        else if (i < 7'd60) f = (b & c) | (b & d) | (c & d);
        else f = b ^ c ^ d;
        return f;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/uuid_v5_namespace_hash_core.sv @@
// UUID version 5 derivation core: 80-stage SHA-1 round pipeline plus output stage.
// Depends on uvnh_pkg.
//
// Usage: one input word (two 64-bit UUID halves, byte 0 on top) per
// in_valid/in_ready handshake; one derived UUID word per out_valid/out_ready
// handshake. Two config registers written via cfg_we/cfg_idx/cfg_data: index 0
// swaps input high-half fields, index 1 output high-half; write only when idle.
// Pipeline: the accepting edge loads the input register, 80 round stages
// follow with the message schedule carried alongside, then the final
// add/mark stage drives out_valid.
// Throughput: one word per cycle while not stalled; each round stage holds one SHA-1 round.
// Stall: when out_valid is high and out_ready low the whole pipeline freezes;
// in_ready follows out_ready or an empty output slot, so nothing is lost or repeated.
// Reset: clears all valid bits and both config registers; no pipeline data
// is cleared.
`default_nettype none
module uuid_v5_namespace_hash_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire uvnh_pkg::in_word_t                  in_data,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output uvnh_pkg::out_word_t                      out_data,
    input  wire logic                                cfg_we,
    input  wire logic [uvnh_pkg::CfgIdxW-1:0]        cfg_idx,
    input  wire logic [uvnh_pkg::CfgDataW-1:0]       cfg_data
);

    localparam int unsigned N = uvnh_pkg::Rounds;

    logic swap_in_reg, swap_out_reg;
    logic advance;

    logic [N:0]                 vld_reg;
    uvnh_pkg::sha_state_t       st_reg  [N+1];
    logic [511:0]               w_reg   [N+1];
    logic                       swo_reg [N+1];
    uvnh_pkg::out_word_t        out_reg;
    logic                       out_vld_reg;

    assign advance   = !out_vld_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_in_reg  <= 1'b0;
            swap_out_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                uvnh_pkg::REG_SWAP_IN:  swap_in_reg  <= cfg_data[0];
                uvnh_pkg::REG_SWAP_OUT: swap_out_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // input stage: build the padded block
    logic [63:0] hi_sw;
    assign hi_sw = swap_in_reg ? uvnh_pkg::swap_fields(in_data.name_uuid_high)
                               : in_data.name_uuid_high;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg     <= {vld_reg[N-1:0], in_valid};
            out_vld_reg <= vld_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st_reg[0]  <= {uvnh_pkg::H0, uvnh_pkg::H1, uvnh_pkg::H2,
                           uvnh_pkg::H3, uvnh_pkg::H4};
            w_reg[0]   <= {uvnh_pkg::NAMESPACE, hi_sw, in_data.name_uuid_low,
                           8'h80, 232'd0, 16'h0100};
            swo_reg[0] <= swap_out_reg;
        end
    end

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_round
            logic [31:0] wi, wn, t, f;
            uvnh_pkg::sha_state_t s;
            assign s  = st_reg[g];
            assign wi = w_reg[g][511:480];
            assign wn = w_reg[g][511:480] ^ w_reg[g][447:416]
                      ^ w_reg[g][255:224] ^ w_reg[g][95:64];
            assign f  = uvnh_pkg::round_f(7'(g), s.b, s.c, s.d);
            assign t  = {s.a[26:0], s.a[31:27]} + f + s.e
                      + uvnh_pkg::round_k(7'(g)) + wi;
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    st_reg[g+1]  <= {t, s.a, {s.b[1:0], s.b[31:2]}, s.c, s.d};
                    w_reg[g+1]   <= {w_reg[g][479:0], wn[30:0], wn[31]};
                    swo_reg[g+1] <= swo_reg[g];
                end
            end
        end
    endgenerate

    // final add, version/variant marking, optional output swap
    uvnh_pkg::sha_state_t sf;
    logic [127:0] dg;
    logic [63:0]  dhi, dlo;
    assign sf  = st_reg[N];
    assign dg  = {sf.a + uvnh_pkg::H0, sf.b + uvnh_pkg::H1,
                  sf.c + uvnh_pkg::H2, sf.d + uvnh_pkg::H3};
    assign dhi = {dg[127:80], 4'h5, dg[75:64]};
    assign dlo = {2'b10, dg[61:0]};

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.derived_uuid_high <= swo_reg[N] ? uvnh_pkg::swap_fields(dhi) : dhi;
            out_reg.derived_uuid_low  <= dlo;
        end
    end

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result dropped under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_vld_reg |-> in_ready)
        else $error("pipeline stalled with empty output");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && vld_reg[N]) |=> out_vld_reg)
        else $error("last round lost its word");

endmodule
`default_nettype wire
